FILE: rtl/pes_pkg.sv
// ----------------------------------------------------------------------------
// Periodic event scheduler package
// Shared constants, types and the command/status structs.
// ----------------------------------------------------------------------------
package pes_pkg;

   localparam int CAPACITY = 1024;
   localparam int ADDR_W   = $clog2(CAPACITY);
   localparam int COUNT_W  = $clog2(CAPACITY + 1);
   localparam int ENTRY_W  = 64;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_EMPTY = 2'd1;
   localparam logic [1:0] STATUS_FULL  = 2'd2;

   localparam logic MODE_REGISTER = 1'b0;
   localparam logic MODE_FIRE     = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_UP_RD,
      ST_UP_CMP,
      ST_FIRE_WAIT,
      ST_DN_RDL,
      ST_DN_RDR,
      ST_DN_CMP,
      ST_RESP
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;        // capture request fields
      logic up_init;     // new entry travels from slot count, count++
      logic up_rd;       // read parent of pos
      logic up_move;     // parent moves down into pos, pos = parent
      logic up_place;    // travelling entry written at pos
      logic fire_rd;     // read root
      logic fire_upd;    // travelling entry = root with next time, pos = 0
      logic dn_rdl;      // read left child
      logic dn_capl;     // capture left child data
      logic dn_rdr;      // read right child
      logic dn_move;     // smaller child moves up into pos, pos = child
      logic dn_place;    // travelling entry written at pos
      logic set_full;
      logic set_empty;
   } cmd_type;

   typedef struct packed {
      logic mode;
      logic full;
      logic empty;
      logic up_done;   // pos is root
      logic up_less;   // travelling entry below the parent just read
      logic dn_leaf;   // no left child
      logic has_right;
      logic dn_stay;   // neither child is below the travelling entry
   } stat_type;

endpackage

FILE: rtl/periodic_event_scheduler_top.sv
// ----------------------------------------------------------------------------
// Periodic event scheduler
// Min-heap of periodic events with register and fire transactions.
// ----------------------------------------------------------------------------
// Channel  Direction  Fields
// req      in         mode, event_id, event_period
// rsp      out        fired_id, status
//
// A transaction on a full or empty store responds straight after dispatch; a
// register sifts the new entry up, reading and comparing one parent at a time
// until it stops or reaches the root; a fire replaces the root with its next
// time and sifts it down, reading the left and then the right child per level.
// Both walks are shaped by the single-port heap memory with its registered read.
// Reset is synchronous; the heap holds no valid state until written.
// The result register holds while rsp_ready is low, and no new transaction
// is taken until the result has gone.
// ----------------------------------------------------------------------------
module periodic_event_scheduler_top import pes_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_mode,
   input  logic [15:0] req_event_id,
   input  logic [15:0] req_event_period,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [15:0] rsp_fired_id,
   output logic [1:0]  rsp_status
);
   cmd_type  cmd;
   stat_type stat;
   logic     busy;

   pes_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_ready, .rsp_valid, .rsp_ready,
      .cmd, .stat, .busy
   );

   pes_datapath u_dp (
      .clock, .reset, .cmd, .stat, .req_mode, .req_event_id,
      .req_event_period, .rsp_fired_id, .rsp_status
   );

`ifndef SYNTH
   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !busy) else $error("ready while busy");
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid)) else $error("ready during response");
   a_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status != 2'd3) else $error("bad status");
`endif
endmodule

FILE: rtl/pes_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One write or one read per cycle; read data registered.
// ----------------------------------------------------------------------------
module pes_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[addr];
   end

   assign rd_data = rd_data_ff;
endmodule

FILE: rtl/pes_datapath.sv
// ----------------------------------------------------------------------------
// Scheduler datapath
// Heap store, position register, cached current entry and compare logic.
// ----------------------------------------------------------------------------
module pes_datapath import pes_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  cmd_type       cmd,
   output stat_type      stat,
   input  logic          req_mode,
   input  logic [15:0]   req_event_id,
   input  logic [15:0]   req_event_period,
   output logic [15:0]   rsp_fired_id,
   output logic [1:0]    rsp_status
);
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [ADDR_W-1:0]  pos_ff, pos_in;
   logic [ENTRY_W-1:0] cur_ff, cur_in;     // entry travelling through the heap
   logic [ENTRY_W-1:0] left_ff, left_in;
   logic               mode_ff, mode_in;
   logic [15:0]        id_ff, id_in;
   logic [15:0]        per_ff, per_in;
   logic [1:0]         status_ff, status_in;
   logic [15:0]        out_id_ff, out_id_in;

   logic               ram_we;
   logic [ADDR_W-1:0]  ram_addr;
   logic [ENTRY_W-1:0] ram_wd, ram_rd;

   pes_ram #(.WIDTH(ENTRY_W), .DEPTH(CAPACITY)) u_ram (
      .clock(clock), .wr_en(ram_we), .addr(ram_addr),
      .wr_data(ram_wd), .rd_data(ram_rd)
   );

   logic [ADDR_W+1:0]  left_idx, right_idx, count_ext;
   logic [ADDR_W-1:0]  parent_idx;
   logic [ENTRY_W-1:0] new_entry;
   logic [32:0]        next_sum;
   logic [31:0]        next_time;
   logic               has_right, left_less, right_best;

   assign left_idx   = {1'b0, pos_ff, 1'b1};
   assign right_idx  = left_idx + 1'b1;
   assign count_ext  = (ADDR_W+2)'(count_ff);
   assign parent_idx = (pos_ff - 1'b1) >> 1;
   assign new_entry  = {16'd0, per_ff, id_ff, per_ff};
   assign next_sum   = {1'b0, ram_rd[63:32]} + {17'd0, ram_rd[15:0]};
   assign next_time  = next_sum[32] ? 32'hFFFF_FFFF : next_sum[31:0];
   assign has_right  = right_idx < count_ext;
   assign left_less  = left_ff < cur_ff;
   // The right child wins only when strictly below the better of the other two.
   assign right_best = has_right && (ram_rd < (left_less ? left_ff : cur_ff));

   always_comb begin
      count_in  = count_ff;
      pos_in    = pos_ff;
      cur_in    = cur_ff;
      left_in   = left_ff;
      mode_in   = mode_ff;
      id_in     = id_ff;
      per_in    = per_ff;
      status_in = status_ff;
      out_id_in = out_id_ff;
      ram_we    = 1'b0;
      ram_addr  = pos_ff;
      ram_wd    = cur_ff;
      if (cmd.load) begin
         mode_in = req_mode;
         id_in   = req_event_id;
         per_in  = req_event_period;
      end
      if (cmd.set_full) begin
         status_in = STATUS_FULL;
         out_id_in = id_ff;
      end
      if (cmd.set_empty) begin
         status_in = STATUS_EMPTY;
         out_id_in = 16'd0;
      end
      if (cmd.up_init) begin
         cur_in    = new_entry;
         pos_in    = ADDR_W'(count_ff);
         count_in  = count_ff + 1'b1;
         status_in = STATUS_OK;
         out_id_in = id_ff;
      end
      if (cmd.up_rd) begin
         ram_addr = parent_idx;
      end
      if (cmd.up_move) begin
         ram_we = 1'b1;
         ram_wd = ram_rd;
         pos_in = parent_idx;
      end
      if (cmd.up_place || cmd.dn_place) begin
         ram_we = 1'b1;
      end
      if (cmd.fire_rd) begin
         ram_addr = '0;
      end
      if (cmd.fire_upd) begin
         cur_in    = {next_time, ram_rd[31:0]};
         out_id_in = ram_rd[31:16];
         status_in = STATUS_OK;
         pos_in    = '0;
      end
      if (cmd.dn_rdl) ram_addr = ADDR_W'(left_idx);
      if (cmd.dn_capl) left_in = ram_rd;
      if (cmd.dn_rdr) ram_addr = ADDR_W'(right_idx);
      if (cmd.dn_move) begin
         ram_we = 1'b1;
         ram_wd = right_best ? ram_rd : left_ff;
         pos_in = right_best ? ADDR_W'(right_idx) : ADDR_W'(left_idx);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
      pos_ff    <= pos_in;
      cur_ff    <= cur_in;
      left_ff   <= left_in;
      mode_ff   <= mode_in;
      id_ff     <= id_in;
      per_ff    <= per_in;
      status_ff <= status_in;
      out_id_ff <= out_id_in;
   end

   assign stat.mode      = mode_ff;
   assign stat.full      = count_ff >= COUNT_W'(CAPACITY);
   assign stat.empty     = count_ff == '0;
   assign stat.up_done   = pos_ff == '0;
   assign stat.up_less   = cur_ff < ram_rd;
   assign stat.dn_leaf   = left_idx >= count_ext;
   assign stat.has_right = has_right;
   assign stat.dn_stay   = !left_less && !right_best;
   assign rsp_fired_id   = out_id_ff;
   assign rsp_status     = status_ff;
endmodule

FILE: rtl/pes_ctrl.sv
// ----------------------------------------------------------------------------
// Scheduler controller
// Sequences register (sift up) and fire (sift down) transactions.
// ----------------------------------------------------------------------------
module pes_ctrl import pes_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   output logic     rsp_valid,
   input  logic     rsp_ready,
   output cmd_type  cmd,
   input  stat_type stat,
   output logic     busy
);
   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      busy      = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            busy      = 1'b0;
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            // Dispatch on the captured mode.
            if (stat.mode == MODE_FIRE) begin
               if (stat.empty) begin
                  cmd.set_empty = 1'b1;
                  state_in      = ST_RESP;
               end else begin
                  cmd.fire_rd = 1'b1;
                  state_in    = ST_FIRE_WAIT;
               end
            end else if (stat.full) begin
               cmd.set_full = 1'b1;
               state_in     = ST_RESP;
            end else begin
               cmd.up_init = 1'b1;
               state_in    = ST_UP_RD;
            end
         end
         ST_UP_RD: begin
            if (stat.up_done) begin
               cmd.up_place = 1'b1;
               state_in     = ST_RESP;
            end else begin
               cmd.up_rd = 1'b1;
               state_in  = ST_UP_CMP;
            end
         end
         ST_UP_CMP: begin
            if (stat.up_less) begin
               cmd.up_move = 1'b1;
               state_in    = ST_UP_RD;
            end else begin
               cmd.up_place = 1'b1;
               state_in     = ST_RESP;
            end
         end
         ST_FIRE_WAIT: begin
            cmd.fire_upd = 1'b1;
            state_in     = ST_DN_RDL;
         end
         ST_DN_RDL: begin
            if (stat.dn_leaf) begin
               cmd.dn_place = 1'b1;
               state_in     = ST_RESP;
            end else begin
               cmd.dn_rdl = 1'b1;
               state_in   = ST_DN_RDR;
            end
         end
         ST_DN_RDR: begin
            cmd.dn_capl = 1'b1;
            cmd.dn_rdr  = stat.has_right;
            state_in    = ST_DN_CMP;
         end
         ST_DN_CMP: begin
            if (stat.dn_stay) begin
               cmd.dn_place = 1'b1;
               state_in     = ST_RESP;
            end else begin
               cmd.dn_move = 1'b1;
               state_in    = ST_DN_RDL;
            end
         end
         ST_RESP: begin
            rsp_valid = 1'b1;
            if (rsp_ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end
endmodule
